[hdl/inode_bitmap_allocator_unit_assert.svh]
// Assertion macros shared by the inode bitmap allocator RTL.
`ifndef INODE_BITMAP_ALLOCATOR_UNIT_ASSERT_SVH
`define INODE_BITMAP_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IBMA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IBMA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/ibma_pkg.sv]
// Shared constants, codes, types and functions of the inode bitmap allocator.
package ibma_pkg;

    localparam int unsigned NUM_SLOTS_DEF = 1024;
    localparam int unsigned WORD_W        = 32;
    localparam int unsigned BIT_W         = 5;
    localparam int unsigned ID_W          = 10;
    localparam int unsigned TOTAL_W       = 11;
    localparam int unsigned TOTAL_MAX     = (1 << TOTAL_W) - 1;

    localparam logic [TOTAL_W-1:0] TOTAL_RESET = TOTAL_W'(1024);
    localparam logic [ID_W-1:0]    ROOT_RESET  = '0;

    // Command codes.
    localparam logic [1:0] CMD_FORMAT = 2'd0;
    localparam logic [1:0] CMD_ALLOC  = 2'd1;
    localparam logic [1:0] CMD_FREE   = 2'd2;
    localparam logic [1:0] CMD_QUERY  = 2'd3;

    // Status codes.
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_RANGE   = 3'd1;
    localparam logic [2:0] ST_NONE    = 3'd2;
    localparam logic [2:0] ST_ALREADY = 3'd3;
    localparam logic [2:0] ST_BAD     = 3'd4;

    // Configuration register indexes.
    localparam logic REG_TOTAL = 1'b0;
    localparam logic REG_ROOT  = 1'b1;

    // Outcome of scanning one bitmap word for a free slot.
    typedef struct packed {
        logic             hit;
        logic [BIT_W-1:0] bit_idx;
    } scan_res_t;

    // Priority encoder: lowest set bit of a word.
    function automatic scan_res_t lowest_set(input logic [WORD_W-1:0] vec);
        scan_res_t res;
        res.hit     = 1'b0;
        res.bit_idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (vec[i]) begin
                res.hit     = 1'b1;
                res.bit_idx = BIT_W'(i);
            end
        end
        return res;
    endfunction

endpackage

[hdl/inode_bitmap_allocator_unit.sv]
// Top level of the inode bitmap allocator: sequencer, counters and ports.
//
//   Channel   Direction  Handshake            Payload
//   s_        in         s_valid / s_ready    s_cmd, s_inode_id
//   m_        out        m_valid / m_ready    m_status, m_result_id, m_used_bit,
//                                             m_free_count
//   cfg_      in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// The bitmap lives in a RAM of WORDS = ceil(NUM_SLOTS/32) words of 32 bits. One request
// is processed at a time. Allocate scans one word per cycle through a shared priority
// encoder; format sweeps every word once; free and query go through the registered RAM
// read port. After reset the block sweeps the RAM clear before s_ready rises.
// A finished result sits in the output register until taken, while the block already
// accepts the next request; configuration writes are taken in every cycle.
module inode_bitmap_allocator_unit #(
    parameter int unsigned NUM_SLOTS = ibma_pkg::NUM_SLOTS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_cmd,
    input  logic [ibma_pkg::ID_W-1:0]     s_inode_id,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [2:0]                    m_status,
    output logic [ibma_pkg::ID_W-1:0]     m_result_id,
    output logic                          m_used_bit,
    output logic [ibma_pkg::TOTAL_W-1:0]  m_free_count,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [ibma_pkg::TOTAL_W-1:0]  cfg_data
);

    localparam int unsigned WORDS = (NUM_SLOTS + ibma_pkg::WORD_W - 1) / ibma_pkg::WORD_W;
    localparam int unsigned AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int unsigned CLAMP = (NUM_SLOTS > ibma_pkg::TOTAL_MAX) ?
                                    ibma_pkg::TOTAL_MAX : NUM_SLOTS;
    localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);
    localparam int unsigned TW = ibma_pkg::TOTAL_W;
    localparam int unsigned IW = ibma_pkg::ID_W;
    localparam int unsigned BW = ibma_pkg::BIT_W;
    localparam int unsigned WW = ibma_pkg::WORD_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_READ,
        S_EVAL,
        S_DONE
    } state_t;

    // Configuration registers.
    logic [TW-1:0] total_reg;
    logic [IW-1:0] root_reg;

    // Sequencer and datapath registers.
    state_t        state_reg,      state_next;
    logic [AW-1:0] addr_reg,       addr_next;
    logic [AW-1:0] eval_addr_reg,  eval_addr_next;
    logic          eval_v_reg,     eval_v_next;
    logic          fmt_reg,        fmt_next;
    logic [1:0]    op_reg,         op_next;
    logic [IW-1:0] id_reg,         id_next;
    logic [TW-1:0] count_reg,      count_next;
    logic [2:0]    res_status_reg, res_status_next;
    logic [IW-1:0] res_id_reg,     res_id_next;
    logic          res_bit_reg,    res_bit_next;

    // Output register.
    logic          m_valid_reg,    m_valid_next;
    logic [2:0]    m_status_reg,   m_status_next;
    logic [IW-1:0] m_id_reg,       m_id_next;
    logic          m_bit_reg,      m_bit_next;
    logic [TW-1:0] m_count_reg,    m_count_next;

    // Bitmap RAM and scan unit.
    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [WW-1:0] ram_wr_data;
    logic [WW-1:0] ram_rd_data;
    ibma_pkg::scan_res_t scan_res;

    logic [TW-1:0] eff_total;
    logic [TW:0]   count_inc;
    logic          slot_bit;

    // The effective total never exceeds the number of physical slots.
    assign eff_total = (total_reg > TW'(CLAMP)) ? TW'(CLAMP) : total_reg;
    assign count_inc = {1'b0, count_reg} + (TW+1)'(1);
    assign slot_bit  = ram_rd_data[id_reg[BW-1:0]];

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_result_id  = m_id_reg;
    assign m_used_bit   = m_bit_reg;
    assign m_free_count = m_count_reg;

    ibma_ram #(
        .WIDTH (WW),
        .DEPTH (WORDS),
        .ADDR_W(AW)
    ) u_map (
        .aclk   (aclk),
        .wr_en  (ram_wr_en),
        .wr_addr(ram_wr_addr),
        .wr_data(ram_wr_data),
        .rd_addr(addr_reg),
        .rd_data(ram_rd_data)
    );

    ibma_scan #(
        .AW(AW)
    ) u_scan (
        .word_data(ram_rd_data),
        .word_addr(eval_addr_reg),
        .eff_total(eff_total),
        .result   (scan_res)
    );

    // Configuration writes are accepted in every cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= ibma_pkg::TOTAL_RESET;
            root_reg  <= ibma_pkg::ROOT_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                ibma_pkg::REG_TOTAL: total_reg <= cfg_data;
                ibma_pkg::REG_ROOT:  root_reg  <= cfg_data[IW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        eval_addr_next  = eval_addr_reg;
        eval_v_next     = eval_v_reg;
        fmt_next        = fmt_reg;
        op_next         = op_reg;
        id_next         = id_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_bit_next    = res_bit_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_id_next       = m_id_reg;
        m_bit_next      = m_bit_reg;
        m_count_next    = m_count_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = addr_reg;
        ram_wr_data     = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            // Sweep every word; a format also plants the root bit on the way.
            S_CLEAR: begin
                ram_wr_en = 1'b1;
                if (fmt_reg && (res_status_reg == ibma_pkg::ST_OK) &&
                    (addr_reg == AW'(root_reg >> BW))) begin
                    ram_wr_data = WW'(1) << root_reg[BW-1:0];
                end
                if (addr_reg == LAST_WORD) begin
                    addr_next  = '0;
                    state_next = fmt_reg ? S_DONE : S_IDLE;
                end else begin
                    addr_next = addr_reg + AW'(1);
                end
            end

            S_IDLE: begin
                if (s_valid) begin
                    op_next = s_cmd;
                    id_next = s_inode_id;
                    case (s_cmd)
                        ibma_pkg::CMD_FORMAT: begin
                            fmt_next    = 1'b1;
                            addr_next   = '0;
                            res_id_next = root_reg;
                            if ({1'b0, root_reg} < eff_total) begin
                                res_status_next = ibma_pkg::ST_OK;
                                res_bit_next    = 1'b1;
                                count_next      = eff_total - TW'(1);
                            end else begin
                                res_status_next = ibma_pkg::ST_RANGE;
                                res_bit_next    = 1'b0;
                                count_next      = eff_total;
                            end
                            state_next = S_CLEAR;
                        end
                        ibma_pkg::CMD_ALLOC: begin
                            if (count_reg == '0) begin
                                res_status_next = ibma_pkg::ST_NONE;
                                res_id_next     = '0;
                                res_bit_next    = 1'b0;
                                state_next      = S_DONE;
                            end else begin
                                addr_next   = '0;
                                eval_v_next = 1'b0;
                                state_next  = S_SCAN;
                            end
                        end
                        default: begin
                            res_id_next = s_inode_id;
                            if ({1'b0, s_inode_id} >= eff_total) begin
                                res_status_next = ibma_pkg::ST_RANGE;
                                res_bit_next    = 1'b0;
                                state_next      = S_DONE;
                            end else begin
                                addr_next  = AW'(s_inode_id >> BW);
                                state_next = S_READ;
                            end
                        end
                    endcase
                end
            end

            // One word is read per cycle while the previous one is searched.
            S_SCAN: begin
                addr_next      = (addr_reg == LAST_WORD) ? addr_reg : addr_reg + AW'(1);
                eval_addr_next = addr_reg;
                eval_v_next    = 1'b1;
                if (eval_v_reg) begin
                    if (scan_res.hit) begin
                        ram_wr_en       = 1'b1;
                        ram_wr_addr     = eval_addr_reg;
                        ram_wr_data     = ram_rd_data | (WW'(1) << scan_res.bit_idx);
                        count_next      = count_reg - TW'(1);
                        res_status_next = ibma_pkg::ST_OK;
                        res_id_next     = IW'({eval_addr_reg, scan_res.bit_idx});
                        res_bit_next    = 1'b1;
                        state_next      = S_DONE;
                    end else if (eval_addr_reg == LAST_WORD) begin
                        res_status_next = ibma_pkg::ST_BAD;
                        res_id_next     = '0;
                        res_bit_next    = 1'b0;
                        state_next      = S_DONE;
                    end
                end
            end

            S_READ: begin
                state_next = S_EVAL;
            end

            S_EVAL: begin
                if (op_reg == ibma_pkg::CMD_QUERY) begin
                    res_status_next = ibma_pkg::ST_OK;
                    res_bit_next    = slot_bit;
                end else if (!slot_bit) begin
                    res_status_next = ibma_pkg::ST_ALREADY;
                    res_bit_next    = 1'b0;
                end else begin
                    ram_wr_en       = 1'b1;
                    ram_wr_data     = ram_rd_data & ~(WW'(1) << id_reg[BW-1:0]);
                    count_next      = (count_inc > {1'b0, eff_total}) ?
                                      eff_total : count_inc[TW-1:0];
                    res_status_next = ibma_pkg::ST_OK;
                    res_bit_next    = 1'b0;
                end
                state_next = S_DONE;
            end

            // Hand the result to the output register once it is free.
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_id_next     = res_id_reg;
                    m_bit_next    = res_bit_reg;
                    m_count_next  = count_reg;
                    fmt_next      = 1'b0;
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            addr_reg    <= '0;
            eval_v_reg  <= 1'b0;
            fmt_reg     <= 1'b0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            addr_reg       <= addr_next;
            eval_addr_reg  <= eval_addr_next;
            eval_v_reg     <= eval_v_next;
            fmt_reg        <= fmt_next;
            op_reg         <= op_next;
            id_reg         <= id_next;
            count_reg      <= count_next;
            res_status_reg <= res_status_next;
            res_id_reg     <= res_id_next;
            res_bit_reg    <= res_bit_next;
            m_valid_reg    <= m_valid_next;
            m_status_reg   <= m_status_next;
            m_id_reg       <= m_id_next;
            m_bit_reg      <= m_bit_next;
            m_count_reg    <= m_count_next;
        end
    end

    // A request is never accepted in two consecutive cycles.
    `include "inode_bitmap_allocator_unit_assert.svh"

    `IBMA_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "accepted back to back")

    // "None free" is only reported with an empty free count.
    `IBMA_ASSERT_NOW(a_none_means_empty, m_valid_reg && (m_status_reg == ibma_pkg::ST_NONE), m_count_reg == '0, "none free with nonzero count")

    // A request that fails never reports its slot as used.
    `IBMA_ASSERT_NOW(a_fail_not_used, m_valid_reg && (m_status_reg != ibma_pkg::ST_OK), !m_bit_reg, "failed request reports a used slot")

endmodule

[hdl/ibma_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ibma_ram #(
    parameter int unsigned WIDTH  = 32,
    parameter int unsigned DEPTH  = 32,
    parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[hdl/ibma_scan.sv]
// Free-slot search over one bitmap word, bounded by the effective total.
module ibma_scan #(
    parameter int unsigned AW = 5
) (
    input  logic [ibma_pkg::WORD_W-1:0]  word_data,
    input  logic [AW-1:0]                word_addr,
    input  logic [ibma_pkg::TOTAL_W-1:0] eff_total,
    output ibma_pkg::scan_res_t          result
);

    localparam int unsigned SW = AW + ibma_pkg::BIT_W;
    localparam int unsigned CW = ((SW > ibma_pkg::TOTAL_W) ? SW : ibma_pkg::TOTAL_W) + 1;

    logic [CW-1:0]               base;
    logic [CW-1:0]               limit;
    logic [CW-1:0]               remain;
    logic [ibma_pkg::WORD_W-1:0] mask;

    // Only slots below the effective total may be handed out.
    always_comb begin
        base   = CW'({word_addr, {ibma_pkg::BIT_W{1'b0}}});
        limit  = CW'(eff_total);
        remain = limit - base;
        if (limit <= base) begin
            mask = '0;
        end else if (remain >= CW'(ibma_pkg::WORD_W)) begin
            mask = '1;
        end else begin
            mask = (ibma_pkg::WORD_W'(1) << remain[ibma_pkg::BIT_W-1:0])
                   - ibma_pkg::WORD_W'(1);
        end
        result = ibma_pkg::lowest_set(~word_data & mask);
    end

endmodule

[verif/inode_bitmap_allocator_unit_tb.sv]
// Self-checking testbench for the inode bitmap allocator with a bit-exact slot map predictor.
`timescale 1ns / 1ps

module inode_bitmap_allocator_unit_tb;

    localparam int unsigned ID_W    = ibma_pkg::ID_W;
    localparam int unsigned TOTAL_W = ibma_pkg::TOTAL_W;
    // The instance runs with the default map size, so the predictor uses the same.
    localparam int unsigned SLOT_COUNT = ibma_pkg::NUM_SLOTS_DEF;
    // Allocation scans up to 32 words, so this stretch of quiet after the
    // last reply is enough to catch a stray one.
    localparam int unsigned SETTLE_CYCLES = 40;
    // The long receiver hold-off used to back the block up into its input.
    localparam int unsigned LONG_STALL_CYCLES = 200;
    // A run with no handshake at all for this many cycles is declared hung.
    localparam int unsigned WATCHDOG_LIMIT = 2000;

    // One request as the sender presents it.
    typedef struct {
        logic [1:0]      cmd;
        logic [ID_W-1:0] id;
    } inode_request_t;

    // One reply as the block is expected to return it.
    typedef struct packed {
        logic [2:0]         status;
        logic [ID_W-1:0]    result_id;
        logic               used_bit;
        logic [TOTAL_W-1:0] free_count;
    } inode_reply_t;

    logic               aclk         = 1'b0;
    logic               aresetn      = 1'b0;
    logic               s_valid      = 1'b0;
    logic               s_ready;
    logic [1:0]         s_cmd        = ibma_pkg::CMD_QUERY;
    logic [ID_W-1:0]    s_inode_id   = '0;
    logic               m_valid;
    logic               m_ready      = 1'b0;
    logic [2:0]         m_status;
    logic [ID_W-1:0]    m_result_id;
    logic               m_used_bit;
    logic [TOTAL_W-1:0] m_free_count;
    logic               cfg_valid    = 1'b0;
    logic               cfg_ready;
    logic               cfg_index    = ibma_pkg::REG_TOTAL;
    logic [TOTAL_W-1:0] cfg_data     = '0;

    // Requests waiting for the driver, and replies the block still owes us.
    inode_request_t pending_requests[$];
    inode_reply_t   awaited_replies[$];
    inode_request_t next_request;
    inode_reply_t   due_reply;

    // Shadow copy of the block's slot map, free counter and registers.
    bit                 shadow_used [SLOT_COUNT];
    int unsigned        shadow_free  = 0;
    logic [TOTAL_W-1:0] shadow_total = ibma_pkg::TOTAL_RESET;
    logic [ID_W-1:0]    shadow_root  = ibma_pkg::ROOT_RESET;

    // Idle rates in percent for each side, and the long hold-off bookkeeping.
    int unsigned sender_idle_pct   = 17;
    int unsigned receiver_idle_pct = 58;
    int unsigned stalls_requested  = 0;
    int unsigned stalls_served     = 0;
    int unsigned stall_cycles_left = 0;
    int unsigned quiet_cycles      = 0;
    int unsigned fail_count        = 0;

    inode_bitmap_allocator_unit uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_inode_id   (s_inode_id),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_result_id  (m_result_id),
        .m_used_bit   (m_used_bit),
        .m_free_count (m_free_count),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 100 MHz clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Applies one command to the shadow state and returns the reply the block
    // must give for it. The total register is clamped to the map size, and
    // the map and counter survive a change of the total until the next format.
    function automatic inode_reply_t apply_inode_command(input logic [1:0] cmd,
                                                         input logic [ID_W-1:0] id);
        inode_reply_t reply;
        int unsigned  limit;
        int unsigned  k;
        int unsigned  slot;
        bit           found;
        reply = '0;
        limit = (shadow_total > SLOT_COUNT) ? SLOT_COUNT : shadow_total;
        found = 1'b0;
        slot  = 0;
        case (cmd)
            ibma_pkg::CMD_FORMAT: begin
                for (k = 0; k < SLOT_COUNT; k++) shadow_used[k] = 1'b0;
                reply.result_id = shadow_root;
                // A root outside the total marks nothing and leaves every slot free.
                if (shadow_root < limit) begin
                    shadow_used[shadow_root] = 1'b1;
                    shadow_free    = limit - 1;
                    reply.status   = ibma_pkg::ST_OK;
                    reply.used_bit = 1'b1;
                end else begin
                    shadow_free  = limit;
                    reply.status = ibma_pkg::ST_RANGE;
                end
            end
            ibma_pkg::CMD_ALLOC: begin
                if (shadow_free == 0) begin
                    reply.status = ibma_pkg::ST_NONE;
                end else begin
                    for (k = 0; k < limit && !found; k++) begin
                        if (!shadow_used[k]) begin
                            found = 1'b1;
                            slot  = k;
                        end
                    end
                    // A nonzero count with no clear slot below the total is
                    // reported as an inconsistent map and changes nothing.
                    if (!found) begin
                        reply.status = ibma_pkg::ST_BAD;
                    end else begin
                        shadow_used[slot] = 1'b1;
                        shadow_free--;
                        reply.status    = ibma_pkg::ST_OK;
                        reply.result_id = ID_W'(slot);
                        reply.used_bit  = 1'b1;
                    end
                end
            end
            ibma_pkg::CMD_FREE: begin
                reply.result_id = id;
                if (id >= limit) begin
                    reply.status = ibma_pkg::ST_RANGE;
                end else if (!shadow_used[id]) begin
                    reply.status = ibma_pkg::ST_ALREADY;
                end else begin
                    shadow_used[id] = 1'b0;
                    shadow_free++;
                    if (shadow_free > limit) shadow_free = limit;
                    reply.status = ibma_pkg::ST_OK;
                end
            end
            default: begin
                reply.result_id = id;
                if (id >= limit) begin
                    reply.status = ibma_pkg::ST_RANGE;
                end else begin
                    reply.status   = ibma_pkg::ST_OK;
                    reply.used_bit = shadow_used[id];
                end
            end
        endcase
        reply.free_count = TOTAL_W'(shadow_free);
        return reply;
    endfunction

    function automatic void check_field(input string what, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            fail_count++;
        end
    endfunction

    // Driver. A request is predicted at the edge where it is accepted, which
    // keeps the shadow state in the same order as the block's own.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                awaited_replies = {awaited_replies, apply_inode_command(s_cmd, s_inode_id)};
            end
            // The request slot is free when nothing is offered or the offer was just taken.
            if (!s_valid || s_ready) begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    next_request = pending_requests.pop_front();
                    s_valid    <= 1'b1;
                    s_cmd      <= next_request.cmd;
                    s_inode_id <= next_request.id;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor. Replies are compared field by field against the oldest
    // prediction; the receiver's ready follows the idle rate, or stays low
    // through a long hold-off counted here when one has been asked for.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_replies.size() == 0) begin
                    $display("%0t: reply with none expected, got status %0d id %0d bit %0d count %0d",
                             $time, m_status, m_result_id, m_used_bit, m_free_count);
                    fail_count++;
                end else begin
                    due_reply = awaited_replies.pop_front();
                    check_field("status", due_reply.status, m_status);
                    check_field("result_id", due_reply.result_id, m_result_id);
                    check_field("used_bit", due_reply.used_bit, m_used_bit);
                    check_field("free_count", due_reply.free_count, m_free_count);
                end
            end
            if (stall_cycles_left != 0) begin
                m_ready           <= 1'b0;
                stall_cycles_left <= stall_cycles_left - 1;
            end else if (stalls_requested != stalls_served) begin
                m_ready           <= 1'b0;
                stalls_served     <= stalls_served + 1;
                stall_cycles_left <= LONG_STALL_CYCLES;
            end else begin
                m_ready <= ($urandom_range(99) >= receiver_idle_pct);
            end
        end
    end

    // Watchdog: any handshake on any channel counts as progress.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic push_request(input logic [1:0] cmd, input logic [ID_W-1:0] id);
        inode_request_t req;
        req.cmd = cmd;
        req.id  = id;
        pending_requests = {pending_requests, req};
    endtask

    // Blocks until every request has been taken and every reply has come back.
    task automatic wait_drained();
        while (pending_requests.size() != 0 || s_valid || awaited_replies.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    // Register writes are only issued while the block is drained, so the
    // shadow registers can be updated right at the accepting edge.
    task automatic write_register(input logic reg_idx, input logic [TOTAL_W-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= reg_idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        if (reg_idx == ibma_pkg::REG_TOTAL) begin
            shadow_total = value;
        end else begin
            shadow_root = value[ID_W-1:0];
        end
        cfg_valid <= 1'b0;
    endtask

    // Random traffic biased toward the low slots, where allocation fills
    // first, so that most frees and queries land on slots in use. A slice of
    // the ids sits on the range boundary or anywhere in the id space.
    task automatic queue_random_requests(input int unsigned count);
        int unsigned limit;
        int unsigned span;
        int unsigned roll;
        int unsigned pick;
        logic [1:0]  cmd;
        logic [ID_W-1:0] id;
        limit = (shadow_total > SLOT_COUNT) ? SLOT_COUNT : shadow_total;
        span  = (limit < 40) ? limit : 40;
        repeat (count) begin
            roll = $urandom_range(99);
            if (roll < 3) cmd = ibma_pkg::CMD_FORMAT;
            else if (roll < 45) cmd = ibma_pkg::CMD_ALLOC;
            else if (roll < 72) cmd = ibma_pkg::CMD_FREE;
            else cmd = ibma_pkg::CMD_QUERY;
            pick = $urandom_range(99);
            if (pick < 12 || span == 0) id = ID_W'($urandom);
            else if (pick < 20) id = ID_W'(limit - 1 + $urandom_range(1));
            else id = ID_W'($urandom_range(span - 1));
            push_request(cmd, id);
        end
    endtask

    // One random phase: drain, set the idle rates and both registers, then
    // usually a format followed by random traffic. A phase without a format
    // keeps the previous map under a new total. The mid-phase pause holds
    // the sender back until every outstanding reply has been taken.
    task automatic run_random_phase(input int unsigned total, input int unsigned root,
                                    input bit do_format, input int unsigned send_pct,
                                    input int unsigned recv_pct, input bit long_stall,
                                    input bit mid_pause);
        wait_drained();
        sender_idle_pct   = send_pct;
        receiver_idle_pct = recv_pct;
        write_register(ibma_pkg::REG_TOTAL, TOTAL_W'(total));
        write_register(ibma_pkg::REG_ROOT, {1'($urandom_range(1)), ID_W'(root)});
        if (long_stall) stalls_requested++;
        if (do_format) push_request(ibma_pkg::CMD_FORMAT, ID_W'($urandom));
        queue_random_requests(mid_pause ? 39 : 78);
        if (mid_pause) begin
            wait_drained();
            queue_random_requests(39);
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset registers: allocate before any format finds nothing free,
        // then a format and a few allocations and frees over the full map.
        push_request(ibma_pkg::CMD_ALLOC, '0);
        push_request(ibma_pkg::CMD_QUERY, 10'd1023);
        push_request(ibma_pkg::CMD_FREE, 10'd1023);
        push_request(ibma_pkg::CMD_FORMAT, 10'h3FF);
        push_request(ibma_pkg::CMD_ALLOC, '0);
        push_request(ibma_pkg::CMD_ALLOC, 10'd1023);
        push_request(ibma_pkg::CMD_FREE, 10'd1);
        push_request(ibma_pkg::CMD_QUERY, 10'd1);
        push_request(ibma_pkg::CMD_ALLOC, '0);
        wait_drained();

        // Tiny total with the root at its last slot: fill it up, then hit
        // the range check, a good free and a double free.
        write_register(ibma_pkg::REG_TOTAL, TOTAL_W'(4));
        write_register(ibma_pkg::REG_ROOT, TOTAL_W'(3));
        push_request(ibma_pkg::CMD_FORMAT, '0);
        push_request(ibma_pkg::CMD_ALLOC, '0);
        push_request(ibma_pkg::CMD_ALLOC, '0);
        push_request(ibma_pkg::CMD_ALLOC, '0);
        push_request(ibma_pkg::CMD_ALLOC, '0);
        push_request(ibma_pkg::CMD_FREE, 10'd4);
        push_request(ibma_pkg::CMD_QUERY, 10'd3);
        push_request(ibma_pkg::CMD_FREE, 10'd3);
        push_request(ibma_pkg::CMD_FREE, 10'd3);
        wait_drained();

        // Shrinking the total after a format leaves a count with no clear
        // slot below the new total, and a free gets clamped to it.
        write_register(ibma_pkg::REG_TOTAL, TOTAL_W'(16));
        write_register(ibma_pkg::REG_ROOT, '0);
        push_request(ibma_pkg::CMD_FORMAT, '0);
        wait_drained();
        write_register(ibma_pkg::REG_TOTAL, TOTAL_W'(2));
        push_request(ibma_pkg::CMD_ALLOC, '0);
        push_request(ibma_pkg::CMD_ALLOC, '0);
        push_request(ibma_pkg::CMD_FREE, '0);
        wait_drained();

        // Zero total: nothing is in range and the count stays at zero.
        write_register(ibma_pkg::REG_TOTAL, '0);
        push_request(ibma_pkg::CMD_FORMAT, '0);
        push_request(ibma_pkg::CMD_ALLOC, '0);
        push_request(ibma_pkg::CMD_QUERY, '0);
        wait_drained();

        // Total above the map size is clamped; the root write carries an
        // extra high bit that the register drops.
        write_register(ibma_pkg::REG_TOTAL, '1);
        write_register(ibma_pkg::REG_ROOT, '1);
        push_request(ibma_pkg::CMD_FORMAT, '0);
        push_request(ibma_pkg::CMD_QUERY, 10'd1023);

        // Random part. Sender light and receiver heavy first, then swapped,
        // then no idling at all.
        run_random_phase(37, 3, 1'b1, 17, 58, 1'b0, 1'b0);
        run_random_phase(8, 0, 1'b1, 17, 58, 1'b1, 1'b0);
        run_random_phase(1024, 512, 1'b1, 58, 17, 1'b0, 1'b0);
        run_random_phase(5, 0, 1'b0, 58, 17, 1'b0, 1'b1);
        run_random_phase(2047, 1023, 1'b1, 0, 0, 1'b0, 1'b0);
        run_random_phase(1, 0, 1'b1, 0, 0, 1'b0, 1'b0);
        run_random_phase(300, 700, 1'b1, 0, 0, 1'b0, 1'b0);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
